// ----- hw/rtl/mf3_pkg.sv -----
// Shared types and constants for the 3x3 median filter stream.
// No dependencies; mf3_front, mf3_median, mf3_back, the top level and the bench import it.
`default_nettype none

package mf3_pkg;

  // Depth of the job queue between the window pipeline and the result serialiser.
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Slots of the up to four results that one pixel can cause, in emission order.
  localparam int EMIT_CENTRE = 0;  // (r-1, c-1)
  localparam int EMIT_RIGHT  = 1;  // (r-1, c), last column only
  localparam int EMIT_BELOW  = 2;  // (r, c-1), last row only
  localparam int EMIT_CORNER = 3;  // (r, c), last row and last column

  typedef logic [7:0] pix_t;
  typedef pix_t [2:0] trio_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [3:0]  emit;
    logic        interior;
  } meta_t;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [3:0]  emit;
    pix_t [3:0]  value;
  } job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mf3_if.sv -----
// Handshake channel interfaces of the median filter: pixel input, result output
// and configuration writes. No package dependencies.
`default_nettype none

interface mf3_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       frame_start;
  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface mf3_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [7:0]  out_value;
  logic        last_of_run;
  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last_of_run, output ready);
endinterface

interface mf3_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mf3_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
// Read during write to the same address returns the old contents. No dependencies.
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mf3_front.sv -----
// Front end of the median filter: position counters, the two line stores and the
// 3x3 window, classifying each pixel's results. Uses mf3_pkg, mf3_if and mf3_ram.
`default_nettype none

module mf3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [10:0]   image_width,
  input  wire logic [11:0]   image_height,
  input  wire logic          room,
  mf3_pix_if.sink            pixels,
  output logic               win_valid,
  output mf3_pkg::win_t      window,
  output mf3_pkg::meta_t     win_meta,
  output logic [1:0]         busy
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          accept;
  logic [CW-1:0] wlast;
  logic [11:0]   rlast;
  logic [CW-1:0] cur_c;
  logic [11:0]   cur_r;
  logic [CW-1:0] col_cnt;
  logic [11:0]   row_cnt;
  logic [CW-1:0] col_cnt_next;
  logic [11:0]   row_cnt_next;
  meta_t         cur_meta;

  logic          s1_valid;
  logic [CW-1:0] s1_addr;
  pix_t          s1_pix;
  meta_t         s1_meta;
  logic          hit;
  pix_t          hold_upper;
  pix_t          hold_lower;
  pix_t          upper_rd;
  pix_t          lower_rd;
  pix_t          upper_eff;
  pix_t          lower_eff;

  assign pixels.ready = room;
  assign accept = pixels.valid && pixels.ready;

  always_comb begin
    logic [12:0] w_ext;
    w_ext = 13'(image_width);
    if (w_ext < 13'd3) begin
      wlast = CW'(2);
    end else if (w_ext > 13'(MAX_WIDTH)) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(w_ext - 13'd1);
    end
    if (image_height < 12'd3) begin
      rlast = 12'd2;
    end else begin
      rlast = image_height - 12'd1;
    end
  end

  // A position left beyond the frame by a size change is pulled back to its last column or row.
  always_comb begin
    if (pixels.frame_start) begin
      cur_c = '0;
      cur_r = '0;
    end else begin
      cur_c = (col_cnt > wlast) ? wlast : col_cnt;
      cur_r = (row_cnt > rlast) ? rlast : row_cnt;
    end
    if (cur_c == wlast) begin
      col_cnt_next = '0;
      row_cnt_next = (cur_r >= rlast) ? 12'd0 : cur_r + 12'd1;
    end else begin
      col_cnt_next = cur_c + CW'(1);
      row_cnt_next = cur_r;
    end
    cur_meta.row                = cur_r;
    cur_meta.col                = 10'(cur_c);
    cur_meta.emit[EMIT_CENTRE]  = (cur_r != 12'd0) && (cur_c != '0);
    cur_meta.emit[EMIT_RIGHT]   = (cur_r != 12'd0) && (cur_c == wlast);
    cur_meta.emit[EMIT_BELOW]   = (cur_r == rlast) && (cur_c != '0);
    cur_meta.emit[EMIT_CORNER]  = (cur_r == rlast) && (cur_c == wlast);
    cur_meta.interior           = (cur_r >= 12'd2) && (cur_c >= CW'(2));
  end

  // The store words read for a pixel are written back in the next cycle, so a pixel that
  // follows at once on the same column takes the values just written instead.
  assign upper_eff = hit ? hold_upper : upper_rd;
  assign lower_eff = hit ? hold_lower : lower_rd;

  mf3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (lower_eff),
    .raddr (cur_c),
    .rdata (upper_rd)
  );

  mf3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_pix),
    .raddr (cur_c),
    .rdata (lower_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_valid <= 1'b0;
      col_cnt   <= '0;
      row_cnt   <= '0;
      window    <= '0;
    end else begin
      s1_valid  <= accept;
      win_valid <= s1_valid;
      if (accept) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
      end
      if (s1_valid) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[2] <= upper_eff;
        window[3] <= window[4];
        window[4] <= window[5];
        window[5] <= lower_eff;
        window[6] <= window[7];
        window[7] <= window[8];
        window[8] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr    <= cur_c;
    s1_pix     <= pixels.pixel_value;
    s1_meta    <= cur_meta;
    hit        <= s1_valid && (s1_addr == cur_c);
    hold_upper <= lower_eff;
    hold_lower <= s1_pix;
    win_meta   <= s1_meta;
  end

  assign busy = {1'b0, s1_valid} + {1'b0, win_valid};

endmodule

`default_nettype wire

// ----- hw/rtl/mf3_median.sv -----
// Median pipeline: sorts the window's columns, reduces them to three candidates
// and picks their median, forming one job per pixel that has a result. Uses mf3_pkg.
`default_nettype none

module mf3_median (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           win_valid,
  input  wire mf3_pkg::win_t  window,
  input  wire mf3_pkg::meta_t win_meta,
  output logic                job_valid,
  output mf3_pkg::job_t       job,
  output logic [1:0]          busy
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Returns the three values in ascending order, lowest at index 0.
  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    trio_t t;
    t[0] = min2(min2(a, b), c);
    t[2] = max2(max2(a, b), c);
    t[1] = med3(a, b, c);
    return t;
  endfunction

  logic        sa_valid;
  trio_t [2:0] sa_col;
  pix_t  [3:0] sa_aux;
  meta_t       sa_meta;

  logic        sb_valid;
  pix_t        sb_lo_max;
  pix_t        sb_mid_med;
  pix_t        sb_hi_min;
  pix_t  [3:0] sb_aux;
  meta_t       sb_meta;

  pix_t        med;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
    end else begin
      sa_valid <= win_valid;
      sb_valid <= sa_valid;
    end
  end

  // Aux slot 0 holds the centre pixel; slots 1 to 3 the right, below and corner
  // border values.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sa_col[j] <= sort3(window[j], window[3 + j], window[6 + j]);
    end
    sa_aux[EMIT_CENTRE] <= window[4];
    sa_aux[EMIT_RIGHT]  <= window[5];
    sa_aux[EMIT_BELOW]  <= window[7];
    sa_aux[EMIT_CORNER] <= window[8];
    sa_meta             <= win_meta;

    sb_lo_max  <= max2(max2(sa_col[0][0], sa_col[1][0]), sa_col[2][0]);
    sb_mid_med <= med3(sa_col[0][1], sa_col[1][1], sa_col[2][1]);
    sb_hi_min  <= min2(min2(sa_col[0][2], sa_col[1][2]), sa_col[2][2]);
    sb_aux     <= sa_aux;
    sb_meta    <= sa_meta;
  end

  assign med = med3(sb_lo_max, sb_mid_med, sb_hi_min);

  always_comb begin
    job.row                = sb_meta.row;
    job.col                = sb_meta.col;
    job.emit               = sb_meta.emit;
    job.value              = sb_aux;
    job.value[EMIT_CENTRE] = sb_meta.interior ? med : sb_aux[EMIT_CENTRE];
  end

  // Pixels on the first row or column cause no result and are dropped here.
  assign job_valid = sb_valid && (sb_meta.emit != 4'b0000);
  assign busy      = {1'b0, sa_valid} + {1'b0, sb_valid};

endmodule

`default_nettype wire

// ----- hw/rtl/mf3_back.sv -----
// Back end of the median filter: the job queue and the serialiser that turns each
// job into its one to four result words. Uses mf3_pkg and mf3_if.
`default_nettype none

module mf3_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire mf3_pkg::job_t job,
  mf3_res_if.source          results,
  output logic [mf3_pkg::QCW-1:0] count
);
  import mf3_pkg::*;

  job_t           queue [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic           load;

  logic           cur_valid;
  job_t           cur;
  logic [3:0]     cur_emit;
  logic           adv;
  logic [3:0]     pick;
  logic [3:0]     rest;
  logic [11:0]    res_row;
  logic [9:0]     res_col;
  pix_t           res_value;

  assign adv  = cur_valid && (!results.valid || results.ready);
  assign rest = cur_emit & ~pick;
  assign load = (count != '0) && (!cur_valid || (adv && (rest == 4'b0000)));

  always_comb begin
    pick      = 4'b0000;
    res_row   = cur.row;
    res_col   = cur.col;
    res_value = cur.value[EMIT_CORNER];
    priority if (cur_emit[EMIT_CENTRE]) begin
      pick[EMIT_CENTRE] = 1'b1;
      res_row   = cur.row - 12'd1;
      res_col   = cur.col - 10'd1;
      res_value = cur.value[EMIT_CENTRE];
    end else if (cur_emit[EMIT_RIGHT]) begin
      pick[EMIT_RIGHT] = 1'b1;
      res_row   = cur.row - 12'd1;
      res_value = cur.value[EMIT_RIGHT];
    end else if (cur_emit[EMIT_BELOW]) begin
      pick[EMIT_BELOW] = 1'b1;
      res_col   = cur.col - 10'd1;
      res_value = cur.value[EMIT_BELOW];
    end else begin
      pick[EMIT_CORNER] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      cur_valid     <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (job_valid) begin
        tail <= (tail == QAW'(QDEPTH - 1)) ? '0 : tail + QAW'(1);
      end
      if (load) begin
        head <= (head == QAW'(QDEPTH - 1)) ? '0 : head + QAW'(1);
      end
      count <= count + QCW'(job_valid) - QCW'(load);
      if (load) begin
        cur_valid <= 1'b1;
      end else if (adv && (rest == 4'b0000)) begin
        cur_valid <= 1'b0;
      end
      if (adv) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      queue[tail] <= job;
    end
    if (load) begin
      cur      <= queue[head];
      cur_emit <= queue[head].emit;
    end else if (adv) begin
      cur_emit <= rest;
    end
    if (adv) begin
      results.out_row     <= res_row;
      results.out_col     <= res_col;
      results.out_value   <= res_value;
      results.last_of_run <= (rest == 4'b0000);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/median_filter_3x3_stream.sv -----
// 3x3 median filter for a stream of 8-bit pixels in raster order. A pixel at row r,
// column c (both at least 1) releases output pixel (r-1, c-1); at the end of a row and
// all through the final row the trailing border pixels follow, up to four result words
// per input word, in order, with last_of_run set on the final one. Interior pixels get
// the median of their 3x3 neighbourhood, border pixels pass through. One pixel is taken
// per clock for as long as the output side takes one result per clock; a pixel with two
// to four results occupies the serialiser for each, since it emits one word a clock, and
// an eight-entry job queue absorbs the difference. A pixel's first result passes the
// front end's registers, the median stages, the job queue and the serialiser. The line
// stores are two RAMs of MAX_WIDTH bytes, each with one write and one read port, and
// need no clearing after reset. Configuration is to be written while idle, which the
// block leaves to the user. Uses mf3_pkg, mf3_if, mf3_front, mf3_median and mf3_back.
`default_nettype none

module median_filter_3x3_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  mf3_pix_if.sink   pixels,
  mf3_res_if.source results,
  mf3_cfg_if.sink   cfg
);
  import mf3_pkg::*;

  logic [10:0]    image_width;
  logic [11:0]    image_height;
  logic           room;
  logic [1:0]     front_busy;
  logic [1:0]     median_busy;
  logic [QCW-1:0] count;
  logic [QCW-1:0] in_flight;

  logic           win_valid;
  win_t           window;
  meta_t          win_meta;
  logic           job_valid;
  job_t           job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 12'd480;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // A pixel is taken only if the queue has a slot for it and for every job in flight.
  assign in_flight = QCW'(front_busy) + QCW'(median_busy);
  assign room      = (QCW'(QDEPTH) - count) > in_flight;

  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .room         (room),
    .pixels       (pixels),
    .win_valid    (win_valid),
    .window       (window),
    .win_meta     (win_meta),
    .busy         (front_busy)
  );

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .window    (window),
    .win_meta  (win_meta),
    .job_valid (job_valid),
    .job       (job),
    .busy      (median_busy)
  );

  mf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .results   (results),
    .count     (count)
  );

endmodule

`default_nettype wire

// ----- bench/median_filter_3x3_stream_test.sv -----
// Self-checking bench for median_filter_3x3_stream: random and directed pixel streams
// against a local prediction of the filtered image, with both handshakes idling at random.
// Depends on mf3_pkg, the mf3 channel interfaces and the filter RTL.
`default_nettype none

module median_filter_3x3_stream_test;
  import mf3_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int SETTLE      = 16;
  localparam int LIMIT_TICKS = 12 * 1200000;

  localparam pix_t CROSS_FRAME [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255,
                                       8'd0, 8'd255};
  localparam pix_t SHUFFLED_FRAME [9] = '{8'd9, 8'd3, 8'd7, 8'd1, 8'd5, 8'd8, 8'd2, 8'd6,
                                          8'd4};
  localparam pix_t CUT_SHORT [4] = '{8'd7, 8'd200, 8'd13, 8'd90};

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    pix_t        value;
    logic        last_of_run;
  } filtered_px_t;

  typedef struct {
    pix_t value;
    logic start;
  } pixel_word_t;

  logic clk;
  logic rst;

  mf3_pix_if pixels ();
  mf3_res_if results ();
  mf3_cfg_if cfg ();

  median_filter_3x3_stream #(.MAX_WIDTH(MAX_W)) uut (
    .clk(clk),
    .rst(rst),
    .pixels(pixels),
    .results(results),
    .cfg(cfg)
  );

  // Local copy of the filter state.
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  pix_t        upper_row [MAX_W];
  pix_t        lower_row [MAX_W];
  pix_t        nbhd [9];
  int          next_col;
  int          next_row;

  filtered_px_t expected_pixels [$];
  pixel_word_t  pending_pixels [$];

  int pixels_queued;
  int pixels_taken;
  int pixels_checked;
  int medians_due;
  int fault_count;
  int sizes_tried;

  int          burst_left;
  int          gap_left;
  pixel_word_t next_word;
  logic [15:0] ready_mask;
  int          mask_age;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pix_t median_of_nine();
    pix_t s [9];
    pix_t t;
    for (int i = 0; i < 9; i++) s[i] = nbhd[i];
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (s[j] > s[j + 1]) begin
          t = s[j];
          s[j] = s[j + 1];
          s[j + 1] = t;
        end
      end
    end
    return s[4];
  endfunction

  // Works out the output pixels that one accepted input word releases.
  function automatic void filter_pixel(pix_t px, logic start);
    int w;
    int h;
    int r;
    int c;
    int n;
    pix_t v;
    filtered_px_t run [4];
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    if (h < 3) h = 3;
    if (start) begin
      next_col = 0;
      next_row = 0;
    end
    c = (next_col < w) ? next_col : w - 1;
    r = (next_row < h) ? next_row : h - 1;
    for (int k = 0; k < 3; k++) begin
      nbhd[k * 3]     = nbhd[k * 3 + 1];
      nbhd[k * 3 + 1] = nbhd[k * 3 + 2];
    end
    nbhd[2] = upper_row[c];
    nbhd[5] = lower_row[c];
    nbhd[8] = px;
    upper_row[c] = lower_row[c];
    lower_row[c] = px;
    n = 0;
    if (r >= 1 && c >= 1) begin
      // The centre of the window is interior once a full row lies above it and a full column to its left.
      if (r >= 2 && c >= 2) begin
        v = median_of_nine();
        medians_due++;
      end else begin
        v = nbhd[4];
      end
      run[n] = '{row: 12'(r - 1), col: 10'(c - 1), value: v, last_of_run: 1'b0};
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      run[n] = '{row: 12'(r - 1), col: 10'(w - 1), value: nbhd[5], last_of_run: 1'b0};
      n++;
    end
    if (r == h - 1 && c >= 1) begin
      run[n] = '{row: 12'(r), col: 10'(c - 1), value: nbhd[7], last_of_run: 1'b0};
      n++;
    end
    if (r == h - 1 && c == w - 1) begin
      run[n] = '{row: 12'(r), col: 10'(w - 1), value: nbhd[8], last_of_run: 1'b0};
      n++;
    end
    if (n > 0) run[n - 1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) expected_pixels.push_back(run[k]);
    if (c >= w - 1) begin
      next_col = 0;
      next_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endfunction

  function automatic void note_fault(string what, filtered_px_t want, filtered_px_t got);
    fault_count++;
    if (fault_count <= 10)
      $display({"%s: expected row %0d col %0d value %0d last %0b, ",
                "got row %0d col %0d value %0d last %0b"},
               what, want.row, want.col, want.value, want.last_of_run,
               got.row, got.col, got.value, got.last_of_run);
  endfunction

  function automatic pix_t random_level();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 3));
      1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_pixel(pix_t v, logic start);
    pending_pixels.push_back('{value: v, start: start});
    pixels_queued++;
  endfunction

  // Random content; noise_pct is the chance of a stray frame start in mid-frame.
  function automatic void queue_random_pixels(int count, bit restart, int noise_pct);
    for (int i = 0; i < count; i++)
      queue_pixel(random_level(), (i == 0 && restart) || ($urandom_range(0, 99) < noise_pct));
  endfunction

  task automatic write_reg(input logic idx, input logic [11:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value[10:0];
    else height_reg = value;
  endtask

  task automatic set_size(input logic [11:0] w, input logic [11:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    sizes_tried++;
  endtask

  // Returns once every queued word has been taken and every result has come back,
  // plus a margin for words still inside the pipeline that release nothing.
  task automatic wait_idle();
    do @(posedge clk); while (pixels_taken != pixels_queued || expected_pixels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (pixels.valid && pixels.ready) begin
        filter_pixel(pixels.pixel_value, pixels.frame_start);
        pixels_taken++;
      end
      if (!pixels.valid || pixels.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pixels.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_word = pending_pixels.pop_front();
          pixels.valid       <= 1'b1;
          pixels.pixel_value <= next_word.value;
          pixels.frame_start <= next_word.start;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = 200;
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 32);
              gap_left = $urandom_range(0, 8);
            end
          end
        end else begin
          pixels.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a rotating mask that is redrawn whenever mask_age runs out.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      ready_mask = 16'hFFFF;
      mask_age = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          note_fault("unexpected result", '0,
                     '{results.out_row, results.out_col, results.out_value, results.last_of_run});
        end else begin
          if ({results.out_row, results.out_col, results.out_value, results.last_of_run}
              !== expected_pixels[0])
            note_fault("mismatch", expected_pixels[0],
                       '{results.out_row, results.out_col, results.out_value, results.last_of_run});
          void'(expected_pixels.pop_front());
        end
        pixels_checked++;
      end
      if (mask_age == 0) begin
        mask_age = 64;
        if ($urandom_range(0, 3) == 0) ready_mask = 16'hFFFF;
        else ready_mask = 16'($urandom) | 16'h0001;
      end
      mask_age--;
      results.ready <= ready_mask[0];
      ready_mask = {ready_mask[0], ready_mask[15:1]};
    end
  end

  initial begin
    int w;
    int h;
    int n;
    int random_items;
    rst = 1'b1;
    pixels.valid = 1'b0;
    pixels.pixel_value = '0;
    pixels.frame_start = 1'b0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.data = '0;
    width_reg = 11'd640;
    height_reg = 12'd480;
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    next_col = 0;
    next_row = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Smallest image: a cross of extremes, a frame cut short by a fresh frame start,
    // then distinct values in shuffled order so the median is a true fifth smallest.
    set_size(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) queue_pixel(CROSS_FRAME[i], i == 0);
    for (int i = 0; i < 4; i++) queue_pixel(CUT_SHORT[i], 1'b0);
    for (int i = 0; i < 9; i++) queue_pixel(SHUFFLED_FRAME[i], i == 0);
    wait_idle();

    // Sizes below the minimum are raised to three.
    set_size(12'd0, 12'd2);
    queue_random_pixels(18, 1'b1, 0);
    wait_idle();
    set_size(12'd2, 12'd1);
    queue_random_pixels(9, 1'b1, 0);
    wait_idle();

    set_size(12'd3, 12'd4095);
    queue_random_pixels(45, 1'b1, 0);
    wait_idle();

    // Shrink both sizes in mid-frame so the position lies past the new last row and column.
    set_size(12'd8, 12'd6);
    queue_random_pixels(38, 1'b1, 0);
    wait_idle();
    set_size(12'd4, 12'd3);
    queue_random_pixels(24, 1'b0, 0);
    wait_idle();

    random_items = 0;
    while (random_items < 150) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 7);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(w, n);
      set_size(12'(w), 12'(h));
      queue_random_pixels(n, 1'b1, 2);
      random_items += n;
      wait_idle();
    end

    $display("Ran %0d pixels through %0d image sizes;", pixels_taken, sizes_tried);
    $display("%0d output words checked, %0d of them medians.", pixels_checked, medians_due);
    if (fault_count == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d faults found", fault_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_TICKS);
    $display("timed out with %0d results outstanding", expected_pixels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_if.sv
hw/rtl/mf3_ram.sv
hw/rtl/mf3_front.sv
hw/rtl/mf3_median.sv
hw/rtl/mf3_back.sv
hw/rtl/median_filter_3x3_stream.sv
bench/median_filter_3x3_stream_test.sv
